// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define CFA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("allocator assertion failed");

// cond must never be true outside reset
`define CFA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("allocator forbidden condition seen");

`endif

// ===== hw/rtl/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and codes shared by the contiguous fit allocator modules.
// ----------------------------------------------------------------------------
package cfa_pkg;

  // op field
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;
  localparam logic [1:0] OP_STATUS  = 2'd3;

  // strategy field
  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_WORST = 2'd2;
  localparam logic [1:0] STRAT_BAD   = 2'd3;

  // result kind
  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_BLOCK  = 2'd1;
  localparam logic [1:0] KIND_HOLE   = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_NO_OWNER  = 3'd2;
  localparam logic [2:0] ST_BAD_STRAT = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // register map
  localparam int         PADDR_W         = 2;
  localparam logic [1:0] ADDR_TOTAL_SIZE = 2'd0;
  localparam logic [31:0] TOTAL_SIZE_RESET = 32'd1048576;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  owner_id;
    logic [31:0] request_size;
    logic [1:0]  strategy;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  entry_owner;
    logic [31:0] entry_start;
    logic [31:0] entry_size;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RQ_SCAN,
    CMD_RQ_COMMIT,
    CMD_RL_SCAN,
    CMD_RL_POS,
    CMD_RL_COMMIT,
    CMD_RL_MISS,
    CMD_MG_STEP,
    CMD_MG_END,
    CMD_SORT,
    CMD_SLIDE,
    CMD_CP_END,
    CMD_LIST
  } cmd_e;

  typedef struct packed {
    cmd_e code;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hole_end;
    logic block_end;
    logic sort_end;
    logic list_last;
    logic found;
  } sts_t;

endpackage

// ===== hw/rtl/cfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfa_ctrl
// Sequencer for the allocator: walks each operation through its table passes.
// ----------------------------------------------------------------------------
module cfa_ctrl #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [1:0]                        in_op_i,
  input  logic                              out_free_i,
  input  cfa_pkg::sts_t                     sts_i,
  output logic                              in_stall_o,
  output cfa_pkg::cmd_t                     cmd_o,
  output logic [$clog2(2*MAX_BLOCKS+2)-1:0] idx_o
);

  localparam int IdxW = $clog2(2*MAX_BLOCKS+2);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RQ_SCAN   = 4'd1;
  localparam logic [3:0] S_RQ_DONE   = 4'd2;
  localparam logic [3:0] S_RL_SCAN   = 4'd3;
  localparam logic [3:0] S_RL_POS    = 4'd4;
  localparam logic [3:0] S_RL_COMMIT = 4'd5;
  localparam logic [3:0] S_MERGE     = 4'd6;
  localparam logic [3:0] S_MG_END    = 4'd7;
  localparam logic [3:0] S_SORT      = 4'd8;
  localparam logic [3:0] S_SLIDE     = 4'd9;
  localparam logic [3:0] S_CP_END    = 4'd10;
  localparam logic [3:0] S_LIST      = 4'd11;

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  cfa_pkg::cmd_e   code;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    code       = cfa_pkg::CMD_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          code  = cfa_pkg::CMD_LOAD;
          idx_d = '0;
          unique case (in_op_i)
            cfa_pkg::OP_REQUEST: state_d = S_RQ_SCAN;
            cfa_pkg::OP_RELEASE: state_d = S_RL_SCAN;
            cfa_pkg::OP_COMPACT: state_d = S_SORT;
            default:             state_d = S_LIST;
          endcase
        end
      end
      S_RQ_SCAN: begin
        if (sts_i.hole_end) begin
          state_d = S_RQ_DONE;
        end else begin
          code  = cfa_pkg::CMD_RQ_SCAN;
          idx_d = idx_q + 1'b1;
        end
      end
      S_RQ_DONE: begin
        if (out_free_i) begin
          code    = cfa_pkg::CMD_RQ_COMMIT;
          state_d = S_IDLE;
        end
      end
      S_RL_SCAN: begin
        if (sts_i.block_end) begin
          idx_d   = '0;
          state_d = S_RL_POS;
        end else begin
          code  = cfa_pkg::CMD_RL_SCAN;
          idx_d = idx_q + 1'b1;
        end
      end
      S_RL_POS: begin
        if (sts_i.hole_end) begin
          state_d = S_RL_COMMIT;
        end else begin
          code  = cfa_pkg::CMD_RL_POS;
          idx_d = idx_q + 1'b1;
        end
      end
      S_RL_COMMIT: begin
        if (sts_i.found) begin
          code    = cfa_pkg::CMD_RL_COMMIT;
          idx_d   = '0;
          state_d = S_MERGE;
        end else if (out_free_i) begin
          code    = cfa_pkg::CMD_RL_MISS;
          state_d = S_IDLE;
        end
      end
      S_MERGE: begin
        if (sts_i.hole_end) begin
          state_d = S_MG_END;
        end else begin
          code  = cfa_pkg::CMD_MG_STEP;
          idx_d = idx_q + 1'b1;
        end
      end
      S_MG_END: begin
        if (out_free_i) begin
          code    = cfa_pkg::CMD_MG_END;
          state_d = S_IDLE;
        end
      end
      S_SORT: begin
        if (sts_i.sort_end) begin
          idx_d   = '0;
          state_d = S_SLIDE;
        end else begin
          code  = cfa_pkg::CMD_SORT;
          idx_d = idx_q + 1'b1;
        end
      end
      S_SLIDE: begin
        if (sts_i.block_end) begin
          state_d = S_CP_END;
        end else begin
          code  = cfa_pkg::CMD_SLIDE;
          idx_d = idx_q + 1'b1;
        end
      end
      S_CP_END: begin
        if (out_free_i) begin
          code    = cfa_pkg::CMD_CP_END;
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free_i) begin
          code = cfa_pkg::CMD_LIST;
          if (sts_i.list_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o.code = code;
  assign cmd_o.emit = (code == cfa_pkg::CMD_RQ_COMMIT) || (code == cfa_pkg::CMD_RL_MISS) ||
                      (code == cfa_pkg::CMD_MG_END) || (code == cfa_pkg::CMD_CP_END) ||
                      (code == cfa_pkg::CMD_LIST);
  assign idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== hw/rtl/cfa_dp.sv =====
// ----------------------------------------------------------------------------
// cfa_dp
// Allocator datapath: hole and block tables, scan registers, result former.
// ----------------------------------------------------------------------------
module cfa_dp #(
  parameter int          MAX_BLOCKS  = 16,
  parameter logic [31:0] TOTAL_RESET = 32'd1048576
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              init_i,
  input  logic [31:0]                       init_size_i,
  input  logic [31:0]                       total_i,
  input  cfa_pkg::in_item_t                 in_i,
  input  cfa_pkg::cmd_t                     cmd_i,
  input  logic [$clog2(2*MAX_BLOCKS+2)-1:0] idx_i,
  output cfa_pkg::sts_t                     sts_o,
  output cfa_pkg::out_item_t                res_o
);

  localparam int HoleDepth = MAX_BLOCKS + 1;
  localparam int HcW  = $clog2(HoleDepth + 1);
  localparam int BcW  = $clog2(MAX_BLOCKS + 1);
  localparam int HiW  = $clog2(HoleDepth);
  localparam int BiW  = $clog2(MAX_BLOCKS);
  localparam int IdxW = $clog2(2*MAX_BLOCKS+2);
  localparam int AccW = 32 + BcW;

  logic [31:0] hs_q [HoleDepth];
  logic [31:0] hs_d [HoleDepth];
  logic [31:0] hz_q [HoleDepth];
  logic [31:0] hz_d [HoleDepth];
  logic [HcW-1:0] hc_q, hc_d;
  logic [31:0] bs_q [MAX_BLOCKS];
  logic [31:0] bs_d [MAX_BLOCKS];
  logic [31:0] bz_q [MAX_BLOCKS];
  logic [31:0] bz_d [MAX_BLOCKS];
  logic [7:0]  bo_q [MAX_BLOCKS];
  logic [7:0]  bo_d [MAX_BLOCKS];
  logic [BcW-1:0] bc_q, bc_d;

  cfa_pkg::in_item_t in_q, in_d;
  logic           pick_valid_q, pick_valid_d;
  logic [HiW-1:0] pick_idx_q, pick_idx_d;
  logic [31:0]    pick_start_q, pick_start_d;
  logic [31:0]    pick_size_q, pick_size_d;
  logic           found_q, found_d;
  logic [BiW-1:0] fnd_idx_q, fnd_idx_d;
  logic [31:0]    fnd_start_q, fnd_start_d;
  logic [31:0]    fnd_size_q, fnd_size_d;
  logic [HcW-1:0] pos_q, pos_d;
  logic [HiW-1:0] w_q, w_d;
  logic [31:0]    acc_start_q, acc_start_d;
  logic [AccW-1:0] acc_end_q, acc_end_d;

  logic [IdxW-1:0] hsel;
  logic [HiW-1:0]  hidx;
  logic [BiW-1:0]  bidx;
  logic [31:0]     h_start, h_size, b_start, b_size;
  logic [7:0]      b_owner;
  logic [AccW-1:0] h_end;
  logic [IdxW-1:0] list_total;
  logic            in_blocks;
  logic            rq_ok;

  // single read port into each table
  assign hsel    = (cmd_i.code == cfa_pkg::CMD_LIST) ? idx_i - IdxW'(bc_q) : idx_i;
  assign hidx    = hsel[HiW-1:0];
  assign bidx    = idx_i[BiW-1:0];
  assign h_start = hs_q[hidx];
  assign h_size  = hz_q[hidx];
  assign h_end   = AccW'(h_start) + AccW'(h_size);
  assign b_start = bs_q[bidx];
  assign b_size  = bz_q[bidx];
  assign b_owner = bo_q[bidx];

  assign list_total = IdxW'(bc_q) + IdxW'(hc_q);
  assign in_blocks  = idx_i < IdxW'(bc_q);

  assign sts_o.hole_end  = idx_i >= IdxW'(hc_q);
  assign sts_o.block_end = idx_i >= IdxW'(bc_q);
  assign sts_o.sort_end  = idx_i >= IdxW'(MAX_BLOCKS);
  assign sts_o.list_last = (idx_i + 1'b1) >= list_total;
  assign sts_o.found     = found_q;

  assign rq_ok = (in_q.strategy != cfa_pkg::STRAT_BAD) && pick_valid_q &&
                 (bc_q < BcW'(MAX_BLOCKS));

  always_comb begin
    hs_d = hs_q;
    hz_d = hz_q;
    hc_d = hc_q;
    bs_d = bs_q;
    bz_d = bz_q;
    bo_d = bo_q;
    bc_d = bc_q;
    in_d = in_q;
    pick_valid_d = pick_valid_q;
    pick_idx_d   = pick_idx_q;
    pick_start_d = pick_start_q;
    pick_size_d  = pick_size_q;
    found_d      = found_q;
    fnd_idx_d    = fnd_idx_q;
    fnd_start_d  = fnd_start_q;
    fnd_size_d   = fnd_size_q;
    pos_d        = pos_q;
    w_d          = w_q;
    acc_start_d  = acc_start_q;
    acc_end_d    = acc_end_q;

    res_o             = '0;
    res_o.kind        = cfa_pkg::KIND_ANSWER;
    res_o.status      = cfa_pkg::ST_OK;
    res_o.last        = 1'b1;

    if (init_i) begin
      hs_d[0] = '0;
      hz_d[0] = init_size_i;
      hc_d    = HcW'(1);
      bc_d    = '0;
    end else begin
      unique case (cmd_i.code)
        cfa_pkg::CMD_LOAD: begin
          in_d         = in_i;
          pick_valid_d = 1'b0;
          found_d      = 1'b0;
          pos_d        = '0;
          w_d          = '0;
          acc_end_d    = '0;
        end
        cfa_pkg::CMD_RQ_SCAN: begin
          if (h_size >= in_q.request_size) begin
            if (!pick_valid_q ||
                (in_q.strategy == cfa_pkg::STRAT_BEST && h_size < pick_size_q) ||
                (in_q.strategy == cfa_pkg::STRAT_WORST && h_size > pick_size_q)) begin
              pick_valid_d = 1'b1;
              pick_idx_d   = hidx;
              pick_start_d = h_start;
              pick_size_d  = h_size;
            end
          end
        end
        cfa_pkg::CMD_RQ_COMMIT: begin
          if (in_q.strategy == cfa_pkg::STRAT_BAD) begin
            res_o.status = cfa_pkg::ST_BAD_STRAT;
          end else if (!pick_valid_q) begin
            res_o.status = cfa_pkg::ST_NO_FIT;
          end else if (!rq_ok) begin
            res_o.status = cfa_pkg::ST_FULL;
          end else begin
            res_o.entry_start = pick_start_q;
            res_o.entry_size  = in_q.request_size;
            bs_d[bc_q[BiW-1:0]] = pick_start_q;
            bz_d[bc_q[BiW-1:0]] = in_q.request_size;
            bo_d[bc_q[BiW-1:0]] = in_q.owner_id;
            bc_d = bc_q + 1'b1;
            if (pick_size_q > in_q.request_size) begin
              hs_d[pick_idx_q] = pick_start_q + in_q.request_size;
              hz_d[pick_idx_q] = pick_size_q - in_q.request_size;
            end else begin
              // hole used up: close the gap above it
              for (int k = 0; k < HoleDepth - 1; k++) begin
                if (k >= int'(pick_idx_q)) begin
                  hs_d[k] = hs_q[k+1];
                  hz_d[k] = hz_q[k+1];
                end
              end
              hc_d = hc_q - 1'b1;
            end
          end
        end
        cfa_pkg::CMD_RL_SCAN: begin
          if (!found_q && b_owner == in_q.owner_id) begin
            found_d     = 1'b1;
            fnd_idx_d   = bidx;
            fnd_start_d = b_start;
            fnd_size_d  = b_size;
          end
        end
        cfa_pkg::CMD_RL_POS: begin
          // holes stay sorted, so this count is the insert slot
          if (h_start <= fnd_start_q) begin
            pos_d = pos_q + 1'b1;
          end
        end
        cfa_pkg::CMD_RL_COMMIT: begin
          for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
            if (k >= int'(fnd_idx_q)) begin
              bs_d[k] = bs_q[k+1];
              bz_d[k] = bz_q[k+1];
              bo_d[k] = bo_q[k+1];
            end
          end
          bc_d = bc_q - 1'b1;
          if (fnd_size_q != '0 && hc_q < HcW'(HoleDepth)) begin
            for (int k = 1; k < HoleDepth; k++) begin
              if (k > int'(pos_q)) begin
                hs_d[k] = hs_q[k-1];
                hz_d[k] = hz_q[k-1];
              end
            end
            hs_d[pos_q[HiW-1:0]] = fnd_start_q;
            hz_d[pos_q[HiW-1:0]] = fnd_size_q;
            hc_d = hc_q + 1'b1;
          end
        end
        cfa_pkg::CMD_RL_MISS: begin
          res_o.status = cfa_pkg::ST_NO_OWNER;
        end
        cfa_pkg::CMD_MG_STEP: begin
          if (idx_i == '0) begin
            acc_start_d = h_start;
            acc_end_d   = h_end;
          end else if (acc_end_q >= AccW'(h_start)) begin
            if (h_end > acc_end_q) begin
              acc_end_d = h_end;
            end
          end else begin
            hs_d[w_q]   = acc_start_q;
            hz_d[w_q]   = acc_end_q[31:0] - acc_start_q;
            w_d         = w_q + 1'b1;
            acc_start_d = h_start;
            acc_end_d   = h_end;
          end
        end
        cfa_pkg::CMD_MG_END: begin
          if (hc_q != '0) begin
            hs_d[w_q] = acc_start_q;
            hz_d[w_q] = acc_end_q[31:0] - acc_start_q;
            hc_d      = HcW'(w_q) + 1'b1;
          end
        end
        cfa_pkg::CMD_SORT: begin
          // odd-even transposition pass; strict compare keeps it stable
          for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
            if ((k & 1) == int'(idx_i[0]) && (k + 1) < int'(bc_q) &&
                bs_q[k] > bs_q[k+1]) begin
              bs_d[k]   = bs_q[k+1];
              bz_d[k]   = bz_q[k+1];
              bo_d[k]   = bo_q[k+1];
              bs_d[k+1] = bs_q[k];
              bz_d[k+1] = bz_q[k];
              bo_d[k+1] = bo_q[k];
            end
          end
        end
        cfa_pkg::CMD_SLIDE: begin
          bs_d[bidx] = acc_end_q[31:0];
          acc_end_d  = acc_end_q + AccW'(b_size);
        end
        cfa_pkg::CMD_CP_END: begin
          hs_d[0] = acc_end_q[31:0];
          hz_d[0] = (acc_end_q <= AccW'(total_i)) ? total_i - acc_end_q[31:0] : '0;
          hc_d    = HcW'(1);
        end
        cfa_pkg::CMD_LIST: begin
          res_o.last = sts_o.list_last;
          if (list_total == '0) begin
            res_o.kind = cfa_pkg::KIND_ANSWER;
          end else if (in_blocks) begin
            res_o.kind        = cfa_pkg::KIND_BLOCK;
            res_o.entry_owner = b_owner;
            res_o.entry_start = b_start;
            res_o.entry_size  = b_size;
          end else begin
            res_o.kind        = cfa_pkg::KIND_HOLE;
            res_o.entry_start = h_start;
            res_o.entry_size  = h_size;
          end
        end
        default: ;
      endcase
    end
  end

  // hole table and table counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HoleDepth; k++) begin
        hs_q[k] <= '0;
        hz_q[k] <= '0;
      end
      hz_q[0] <= TOTAL_RESET;
      hc_q    <= HcW'(1);
      bc_q    <= '0;
    end else begin
      hs_q <= hs_d;
      hz_q <= hz_d;
      hc_q <= hc_d;
      bc_q <= bc_d;
    end
  end

  // block entries and scratch registers: no reset needed
  always_ff @(posedge clk_i) begin
    bs_q         <= bs_d;
    bz_q         <= bz_d;
    bo_q         <= bo_d;
    in_q         <= in_d;
    pick_valid_q <= pick_valid_d;
    pick_idx_q   <= pick_idx_d;
    pick_start_q <= pick_start_d;
    pick_size_q  <= pick_size_d;
    found_q      <= found_d;
    fnd_idx_q    <= fnd_idx_d;
    fnd_start_q  <= fnd_start_d;
    fnd_size_q   <= fnd_size_d;
    pos_q        <= pos_d;
    w_q          <= w_d;
    acc_start_q  <= acc_start_d;
    acc_end_q    <= acc_end_d;
  end

endmodule

// ===== hw/rtl/contiguous_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Contiguous memory allocator with first, best and worst fit, release with
// hole merging, compaction and a status listing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one command item.
//   One item is worked on at a time; in_stall_o stays high until its last
//   result item has been handed to the output register.
//   Output channel (out_valid_o / out_stall_i / out_data_o) is driven from a
//   register. Request, release and compact give one answer item; a status
//   listing gives one item per block then one per hole, last set on the final.
//   A request scans the holes, then commits; a release scans the blocks, finds
//   the insert slot among the holes, commits and merges the holes (no owner on
//   a miss); compact sorts the blocks, slides them down and leaves one hole;
//   status lists the blocks, then the holes. The sequencer steps one table
//   entry per cycle through each table's port, a listing only into a free
//   output slot. A stalled receiver holds the output register; the sequencer
//   waits. Reset: one hole (0, total size), no blocks, total size 1 MiB masked
//   to ADDR_BITS. Writing total_size over APB resets the tables the same way;
//   write it only while the block is idle. The tables are ready at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module contiguous_fit_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int ADDR_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cfa_pkg::in_item_t            in_data_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cfa_pkg::out_item_t           out_data_o,
  // APB register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int IdxW = $clog2(2*MAX_BLOCKS+2);
  // total size is kept to ADDR_BITS; the register itself is 32 bits
  localparam logic [31:0] AddrMask =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [31:0] TotalReset = cfa_pkg::TOTAL_SIZE_RESET & AddrMask;

  logic [31:0]        total_q, total_d;
  logic               cfg_we;
  logic               out_valid_q, out_valid_d;
  cfa_pkg::out_item_t out_data_q;
  cfa_pkg::out_item_t res;
  cfa_pkg::cmd_t      cmd;
  cfa_pkg::sts_t      sts;
  logic [IdxW-1:0]    idx;
  logic               out_free;

  // --- register port -------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && (paddr == cfa_pkg::ADDR_TOTAL_SIZE);
  assign total_d = cfg_we ? (pwdata & AddrMask) : total_q;
  assign prdata  = (paddr == cfa_pkg::ADDR_TOTAL_SIZE) ? total_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
    end else begin
      total_q <= total_d;
    end
  end

  // --- sequencer and datapath ----------------------------------------------
  // the output slot is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  cfa_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (in_data_i.op),
    .out_free_i(out_free),
    .sts_i     (sts),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .idx_o     (idx)
  );

  cfa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .TOTAL_RESET(TotalReset)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (cfg_we),
    .init_size_i(pwdata & AddrMask),
    .total_i    (total_q),
    .in_i       (in_data_i),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .sts_o      (sts),
    .res_o      (res)
  );

  // --- output register -------------------------------------------------------
  // the sequencer only emits when the slot is free
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --- assertions --------------------------------------------------------------
  // an accepted command always keeps the block busy on the next cycle
  `CFA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // a listing item that is not the final one means the listing is still running
  `CFA_ASSERT_NEVER(a_idle_mid_list, clk_i, rst_ni, out_valid_o && !out_data_o.last && !in_stall_o)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the contiguous fit allocator. A directed table runs
// first, then random requests, releases, compactions and status listings under
// several memory sizes, with random command gaps and result stalls. Every result
// item is checked against a local predictor or a hand-written answer.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NBLK      = 16;
  localparam int NHOLE     = NBLK + 1;
  localparam int IDLE_LIMIT = 4000;  // cycles without any handshake
  localparam int ITEMS_PER_SETTING = 100;

  // ports
  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  cfa_pkg::in_item_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  cfa_pkg::out_item_t          out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [cfa_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  contiguous_fit_allocator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // --------------------------------------------------------------------------
  // Allocator shadow state. Sums of start and size are kept at 64 bits so
  // that hole merging never wraps, even with a 4 GiB memory.
  // --------------------------------------------------------------------------
  logic [63:0] mem_size;
  logic [63:0] hole_base [NHOLE];
  logic [63:0] hole_len  [NHOLE];
  int          num_holes;
  logic [63:0] blk_base  [NBLK];
  logic [63:0] blk_len   [NBLK];
  logic [7:0]  blk_owner [NBLK];
  int          num_blocks;

  cfa_pkg::out_item_t pending_results[$];
  int          err_count;
  bit          quiet;       // no gaps and no stalls while set
  bit          in_taken;    // command handshake due at the next edge
  bit          out_taken;   // result handshake due at the next edge

  task automatic clear_tables();
    num_holes    = 1;
    hole_base[0] = '0;
    hole_len[0]  = mem_size;
    num_blocks   = 0;
  endtask

  task automatic push_result(logic [1:0] kind, logic [2:0] status, logic [7:0] owner,
                             logic [63:0] base, logic [63:0] len, bit last);
    cfa_pkg::out_item_t r;
    r.kind        = kind;
    r.status      = status;
    r.entry_owner = owner;
    r.entry_start = base[31:0];
    r.entry_size  = len[31:0];
    r.last        = last;
    pending_results.push_back(r);
  endtask

  // sort holes by start (stable insertion), then fold touching/overlapping
  task automatic coalesce_holes();
    logic [63:0] s, z, pend, cend;
    int j, w;
    if (num_holes < 2) return;
    for (int i = 1; i < num_holes; i++) begin
      s = hole_base[i];
      z = hole_len[i];
      j = i;
      while (j > 0 && hole_base[j-1] > s) begin
        hole_base[j] = hole_base[j-1];
        hole_len[j]  = hole_len[j-1];
        j--;
      end
      hole_base[j] = s;
      hole_len[j]  = z;
    end
    w = 0;
    for (int i = 1; i < num_holes; i++) begin
      pend = hole_base[w] + hole_len[w];
      cend = hole_base[i] + hole_len[i];
      if (pend >= hole_base[i]) begin
        if (cend > pend) hole_len[w] = cend - hole_base[w];
      end else begin
        w++;
        hole_base[w] = hole_base[i];
        hole_len[w]  = hole_len[i];
      end
    end
    num_holes = w + 1;
  endtask

  task automatic allocate(cfa_pkg::in_item_t it);
    logic [63:0] want, base;
    int pick;
    want = {32'd0, it.request_size};
    pick = -1;
    if (it.strategy == cfa_pkg::STRAT_BAD) begin
      push_result(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_BAD_STRAT, '0, '0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < num_holes; i++) begin
      if (hole_len[i] < want) continue;
      if (pick < 0) begin
        pick = i;
        if (it.strategy == cfa_pkg::STRAT_FIRST) break;
      end else if (it.strategy == cfa_pkg::STRAT_BEST && hole_len[i] < hole_len[pick]) begin
        pick = i;
      end else if (it.strategy == cfa_pkg::STRAT_WORST && hole_len[i] > hole_len[pick]) begin
        pick = i;
      end
    end
    if (pick < 0) begin
      push_result(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_NO_FIT, '0, '0, '0, 1'b1);
      return;
    end
    if (num_blocks >= NBLK) begin
      push_result(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_FULL, '0, '0, '0, 1'b1);
      return;
    end
    base = hole_base[pick];
    blk_base[num_blocks]  = base;
    blk_len[num_blocks]   = want;
    blk_owner[num_blocks] = it.owner_id;
    num_blocks++;
    if (hole_len[pick] > want) begin
      hole_base[pick] = base + want;
      hole_len[pick]  = hole_len[pick] - want;
    end else begin
      for (int i = pick; i + 1 < num_holes; i++) begin
        hole_base[i] = hole_base[i+1];
        hole_len[i]  = hole_len[i+1];
      end
      num_holes--;
    end
    push_result(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_OK, '0, base, want, 1'b1);
  endtask

  task automatic free_owner(logic [7:0] owner);
    int idx;
    idx = num_blocks;
    for (int i = 0; i < num_blocks; i++) begin
      if (blk_owner[i] == owner) begin
        idx = i;
        break;
      end
    end
    if (idx >= num_blocks) begin
      push_result(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_NO_OWNER, '0, '0, '0, 1'b1);
      return;
    end
    // an empty block gives back nothing
    if (blk_len[idx] != 0 && num_holes < NHOLE) begin
      hole_base[num_holes] = blk_base[idx];
      hole_len[num_holes]  = blk_len[idx];
      num_holes++;
    end
    for (int k = idx; k + 1 < num_blocks; k++) begin
      blk_base[k]  = blk_base[k+1];
      blk_len[k]   = blk_len[k+1];
      blk_owner[k] = blk_owner[k+1];
    end
    num_blocks--;
    coalesce_holes();
    push_result(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_OK, '0, '0, '0, 1'b1);
  endtask

  task automatic compact_blocks();
    logic [63:0] s, z, cur;
    logic [7:0]  o;
    int j;
    for (int i = 1; i < num_blocks; i++) begin
      s = blk_base[i];
      z = blk_len[i];
      o = blk_owner[i];
      j = i;
      while (j > 0 && blk_base[j-1] > s) begin
        blk_base[j]  = blk_base[j-1];
        blk_len[j]   = blk_len[j-1];
        blk_owner[j] = blk_owner[j-1];
        j--;
      end
      blk_base[j]  = s;
      blk_len[j]   = z;
      blk_owner[j] = o;
    end
    cur = '0;
    for (int i = 0; i < num_blocks; i++) begin
      blk_base[i] = cur;
      cur += blk_len[i];
    end
    num_holes    = 1;
    hole_base[0] = cur;
    hole_len[0]  = (cur <= mem_size) ? mem_size - cur : '0;
    push_result(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_OK, '0, '0, '0, 1'b1);
  endtask

  task automatic list_tables();
    int total, k;
    total = num_blocks + num_holes;
    if (total == 0) begin
      push_result(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_OK, '0, '0, '0, 1'b1);
      return;
    end
    k = 0;
    for (int i = 0; i < num_blocks; i++) begin
      k++;
      push_result(cfa_pkg::KIND_BLOCK, cfa_pkg::ST_OK, blk_owner[i], blk_base[i], blk_len[i],
                  k == total);
    end
    for (int i = 0; i < num_holes; i++) begin
      k++;
      push_result(cfa_pkg::KIND_HOLE, cfa_pkg::ST_OK, '0, hole_base[i], hole_len[i],
                  k == total);
    end
  endtask

  task automatic predict_allocator(cfa_pkg::in_item_t it);
    case (it.op)
      cfa_pkg::OP_REQUEST: allocate(it);
      cfa_pkg::OP_RELEASE: free_owner(it.owner_id);
      cfa_pkg::OP_COMPACT: compact_blocks();
      default:             list_tables();
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset, handshake sampling
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall and valid only move at rising edges, so the falling edge sees the
  // values that decide the next handshake.
  always @(negedge clk) begin
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (out_taken) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", 64'(out_data.entry_start), '0);
      end else begin
        cfa_pkg::out_item_t want;
        want = pending_results.pop_front();
        if (out_data.kind != want.kind)
          report_mismatch("kind", 64'(out_data.kind), 64'(want.kind));
        if (out_data.status != want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.entry_owner != want.entry_owner)
          report_mismatch("entry_owner", 64'(out_data.entry_owner), 64'(want.entry_owner));
        if (out_data.entry_start != want.entry_start)
          report_mismatch("entry_start", 64'(out_data.entry_start), 64'(want.entry_start));
        if (out_data.entry_size != want.entry_size)
          report_mismatch("entry_size", 64'(out_data.entry_size), 64'(want.entry_size));
        if (out_data.last != want.last)
          report_mismatch("last", 64'(out_data.last), 64'(want.last));
      end
    end
  end

  // result side stalls at random, 23 times in 100, outside reset and quiet
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 23);
    end
  end

  // watchdog: any handshake restarts the count
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || in_taken || out_taken) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------
  task automatic send_item(cfa_pkg::in_item_t it, bit typed, cfa_pkg::out_item_t typed_answer);
    if (!quiet && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    forever begin
      @(negedge clk);
      @(posedge clk);
      if (in_taken) break;
    end
    predict_allocator(it);
    // rows with a hand-written answer replace what the predictor queued
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(typed_answer);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= cfa_pkg::ADDR_TOTAL_SIZE;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (!wr && prdata != mem_size[31:0])
      report_mismatch("total_size readback", 64'(prdata), mem_size);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_memory_size(logic [31:0] sz);
    apb_access(1'b1, sz);
    mem_size = {32'd0, sz};
    clear_tables();
    apb_access(1'b0, '0);
  endtask

  function automatic cfa_pkg::in_item_t make_cmd(logic [1:0] op, logic [7:0] owner,
                                                 logic [31:0] sz, logic [1:0] strat);
    cfa_pkg::in_item_t c;
    c.op           = op;
    c.owner_id     = owner;
    c.request_size = sz;
    c.strategy     = strat;
    return c;
  endfunction

  function automatic cfa_pkg::out_item_t make_answer(logic [1:0] kind, logic [2:0] status,
                                                     logic [31:0] base, logic [31:0] len);
    cfa_pkg::out_item_t r;
    r.kind        = kind;
    r.status      = status;
    r.entry_owner = '0;
    r.entry_start = base;
    r.entry_size  = len;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic cfa_pkg::in_item_t random_cmd();
    logic [31:0] sz;
    logic [7:0]  owner;
    logic [1:0]  op;
    int r;
    r  = $urandom_range(0, 99);
    op = (r < 55) ? cfa_pkg::OP_REQUEST :
         (r < 82) ? cfa_pkg::OP_RELEASE :
         (r < 90) ? cfa_pkg::OP_COMPACT : cfa_pkg::OP_STATUS;
    // small owner pool so releases usually find their block
    owner = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 10)      sz = '0;
    else if (r < 20) sz = $urandom;
    else if (r < 28) sz = mem_size[31:0] >> $urandom_range(0, 4);
    else             sz = $urandom_range(0, (mem_size[31:0] >> 4) + 1);
    return make_cmd(op, owner, sz, ($urandom_range(0, 9) == 0) ? cfa_pkg::STRAT_BAD
                                                              : 2'($urandom_range(0, 2)));
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: extremes, error codes, every op and strategy
  // --------------------------------------------------------------------------
  typedef struct {
    cfa_pkg::in_item_t  cmd;
    bit                 typed;
    cfa_pkg::out_item_t answer;
  } dir_row_t;

  dir_row_t           dir_rows[$];
  cfa_pkg::out_item_t none_ans;
  logic [31:0]        sizes [5];

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    quiet     = 1'b0;
    err_count = 0;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    none_ans  = '0;
    mem_size  = {32'd0, cfa_pkg::TOTAL_SIZE_RESET};
    clear_tables();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // status right after reset: one hole covering all of memory
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_STATUS, 8'hFF, 32'hFFFFFFFF, cfa_pkg::STRAT_BAD),
                         1'b1, make_answer(cfa_pkg::KIND_HOLE, cfa_pkg::ST_OK, '0,
                                           cfa_pkg::TOTAL_SIZE_RESET)});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h00, 32'd0, cfa_pkg::STRAT_BAD), 1'b1,
                         make_answer(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_BAD_STRAT, '0, '0)});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'hFF, 32'hFFFFFFFF,
                                  cfa_pkg::STRAT_FIRST), 1'b1,
                         make_answer(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_NO_FIT, '0, '0)});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_RELEASE, 8'h09, 32'd0, cfa_pkg::STRAT_FIRST), 1'b1,
                         make_answer(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_NO_OWNER, '0, '0)});
    // zero-size request takes nothing from the hole
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h01, 32'd0, cfa_pkg::STRAT_FIRST), 1'b1,
                         make_answer(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_OK, '0, '0)});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h02, 32'd100, cfa_pkg::STRAT_FIRST),
                         1'b1, make_answer(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_OK, '0, 32'd100)});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h03, 32'd200, cfa_pkg::STRAT_BEST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h04, 32'd300, cfa_pkg::STRAT_WORST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h05, 32'd50, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_RELEASE, 8'h02, 32'd0, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_RELEASE, 8'h04, 32'd0, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    // best fit takes the small hole, worst fit the big trailing one
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h06, 32'd60, cfa_pkg::STRAT_BEST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h07, 32'd40, cfa_pkg::STRAT_WORST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_STATUS, 8'h00, 32'd0, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    // zero-size release: block goes, no hole appears
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_RELEASE, 8'h01, 32'd0, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_RELEASE, 8'h03, 32'd0, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_COMPACT, 8'hFF, 32'hFFFFFFFF, cfa_pkg::STRAT_BAD),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_STATUS, 8'h00, 32'd0, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    // exact fit removes the trailing hole
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'hFF,
                                  cfa_pkg::TOTAL_SIZE_RESET - 32'd150, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_STATUS, 8'h00, 32'd0, cfa_pkg::STRAT_FIRST),
                         1'b0, none_ans});
    dir_rows.push_back('{make_cmd(cfa_pkg::OP_REQUEST, 8'h08, 32'd1, cfa_pkg::STRAT_WORST), 1'b1,
                         make_answer(cfa_pkg::KIND_ANSWER, cfa_pkg::ST_NO_FIT, '0, '0)});

    foreach (dir_rows[i]) send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].answer);
    drain();

    // ------------------------------------------------------------------------
    // Random part over several memory sizes, extremes included
    // ------------------------------------------------------------------------
    sizes[0] = 32'd0;
    sizes[1] = 32'hFFFFFFFF;
    sizes[2] = 32'd1;
    sizes[3] = 32'd256;
    sizes[4] = $urandom;
    for (int p = 0; p < 5; p++) begin
      set_memory_size(sizes[p]);
      quiet = (p == 3);   // one setting runs with no gaps and no stalls
      for (int n = 0; n < ITEMS_PER_SETTING; n++) send_item(random_cmd(), 1'b0, none_ans);
      drain();
      quiet = 1'b0;
    end

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_ctrl.sv
hw/rtl/cfa_dp.sv
hw/rtl/contiguous_fit_allocator.sv
tb/testbench.sv
